### rtl/ddp_pkg.sv
// ----------------------------------------------------------------------------
// Door drive position package
// Shared types and constants for the door drive position machine: the
// state encoding, the request and response beat layouts and the register map.
// ----------------------------------------------------------------------------
package ddp_pkg;

   // Widths of the speed path.
   localparam int MAG_WIDTH   = 10;
   localparam int SPEED_WIDTH = 11;
   localparam int SW_COUNT    = 4;

   // Register map of the configuration port.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = MAG_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOW_SPEED = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAST_SPEED = 1'b1;

   localparam logic [MAG_WIDTH-1:0] SLOW_SPEED_RESET = 10'd200;
   localparam logic [MAG_WIDTH-1:0] FAST_SPEED_RESET = 10'd600;

   // Door position machine states.
   typedef enum logic [3:0] {
      ST_INIT    = 4'd0,
      ST_UNSURE  = 4'd1,
      ST_CLOSED  = 4'd2,
      ST_NEG     = 4'd3,
      ST_ACCNEG  = 4'd4,
      ST_DECNEG  = 4'd5,
      ST_OPEN    = 4'd6,
      ST_POS     = 4'd7,
      ST_ACCPOS  = 4'd8,
      ST_DECPOS  = 4'd9
   } door_state_type;

   // Request beat: one switch sample and a direction request.
   typedef struct packed {
      logic switch_one;
      logic switch_two;
      logic switch_three;
      logic switch_four;
      logic direction;
   } req_type;

   // Response beat: speed command and machine state after the tick.
   typedef struct packed {
      logic signed [SPEED_WIDTH-1:0] drive_speed;
      logic [3:0]                    door_state;
   } rsp_type;

   // Machine state carried from one tick to the next.
   typedef struct packed {
      door_state_type                state;
      logic [SW_COUNT-1:0]           prev_switches;
      logic signed [SPEED_WIDTH-1:0] speed;
   } ctx_type;

endpackage

### rtl/ddp_next_state.sv
// ----------------------------------------------------------------------------
// Door drive next state
// Combinational step of the position machine: from the current context and
// one switch sample it forms the next state, speed and switch history.
// ----------------------------------------------------------------------------
module ddp_next_state (
   input  ddp_pkg::ctx_type              cur,
   input  ddp_pkg::req_type              req,
   input  logic [ddp_pkg::MAG_WIDTH-1:0] slow_speed,
   input  logic [ddp_pkg::MAG_WIDTH-1:0] fast_speed,
   output ddp_pkg::ctx_type              nxt
);

   logic [ddp_pkg::SW_COUNT-1:0]           sw;
   logic [ddp_pkg::SW_COUNT-1:0]           ch;
   logic                                   d0;
   logic                                   d1;
   logic signed [ddp_pkg::SPEED_WIDTH-1:0] slow_pos;
   logic signed [ddp_pkg::SPEED_WIDTH-1:0] slow_neg;
   logic signed [ddp_pkg::SPEED_WIDTH-1:0] fast_pos;
   logic signed [ddp_pkg::SPEED_WIDTH-1:0] fast_neg;
   ddp_pkg::door_state_type                state_next;
   logic signed [ddp_pkg::SPEED_WIDTH-1:0] speed_next;

   // Switch levels, zone changes and direction.
   assign sw = {req.switch_four, req.switch_three, req.switch_two, req.switch_one};
   assign ch = sw ^ cur.prev_switches;
   assign d1 = req.direction;
   assign d0 = ~req.direction;

   // Signed speed commands from the magnitude registers.
   assign slow_pos = $signed({1'b0, slow_speed});
   assign fast_pos = $signed({1'b0, fast_speed});
   assign slow_neg = -slow_pos;
   assign fast_neg = -fast_pos;

   // Next state. Later rules override earlier ones, as in the rule lists.
   always_comb begin
      state_next = cur.state;
      case (cur.state)
         ddp_pkg::ST_INIT: begin
            if (sw == '0) state_next = ddp_pkg::ST_UNSURE;
         end
         ddp_pkg::ST_UNSURE: begin
            if (d0 && ch[0]) state_next = ddp_pkg::ST_CLOSED;
            if (d1 && ch[0]) state_next = ddp_pkg::ST_NEG;
            if (d1 && ch[1]) state_next = ddp_pkg::ST_ACCNEG;
            if (d1 && ch[2]) state_next = ddp_pkg::ST_DECNEG;
            if (d1 && ch[3]) state_next = ddp_pkg::ST_OPEN;
            if (d0 && ch[3]) state_next = ddp_pkg::ST_POS;
            if (d0 && ch[2]) state_next = ddp_pkg::ST_ACCPOS;
            if (d0 && ch[1]) state_next = ddp_pkg::ST_DECPOS;
         end
         ddp_pkg::ST_CLOSED: begin
            if (d1) state_next = ddp_pkg::ST_NEG;
         end
         ddp_pkg::ST_NEG: begin
            if (d1 && ch[1]) state_next = ddp_pkg::ST_ACCNEG;
            if (d0) state_next = ddp_pkg::ST_DECPOS;
         end
         ddp_pkg::ST_ACCNEG: begin
            if (d1 && ch[2]) state_next = ddp_pkg::ST_DECNEG;
            if (d0) state_next = ddp_pkg::ST_ACCPOS;
         end
         ddp_pkg::ST_DECNEG: begin
            if (d1 && ch[3]) state_next = ddp_pkg::ST_OPEN;
            if (d0) state_next = ddp_pkg::ST_POS;
         end
         ddp_pkg::ST_OPEN: begin
            if (d0) state_next = ddp_pkg::ST_POS;
         end
         ddp_pkg::ST_POS: begin
            if (d0 && ch[2]) state_next = ddp_pkg::ST_ACCPOS;
            if (d1) state_next = ddp_pkg::ST_DECNEG;
         end
         ddp_pkg::ST_ACCPOS: begin
            if (d0 && ch[1]) state_next = ddp_pkg::ST_DECPOS;
            if (d1) state_next = ddp_pkg::ST_ACCNEG;
         end
         ddp_pkg::ST_DECPOS: begin
            if (d0 && ch[0]) state_next = ddp_pkg::ST_CLOSED;
            if (d1) state_next = ddp_pkg::ST_NEG;
         end
         default: begin
            state_next = cur.state;
         end
      endcase
   end

   // Speed follows the state at the start of the tick; init and unknown hold it.
   always_comb begin
      case (cur.state)
         ddp_pkg::ST_CLOSED,
         ddp_pkg::ST_OPEN:   speed_next = '0;
         ddp_pkg::ST_NEG,
         ddp_pkg::ST_DECNEG: speed_next = slow_neg;
         ddp_pkg::ST_ACCNEG: speed_next = fast_neg;
         ddp_pkg::ST_POS,
         ddp_pkg::ST_DECPOS: speed_next = slow_pos;
         ddp_pkg::ST_ACCPOS: speed_next = fast_pos;
         default:            speed_next = cur.speed;
      endcase
   end

   assign nxt.state         = state_next;
   assign nxt.prev_switches = sw;
   assign nxt.speed         = speed_next;

endmodule

### rtl/door_drive_position_fsm.sv
// ----------------------------------------------------------------------------
// Door drive position machine
// Steps a ten-state door position machine once per switch sample and returns
// the signed drive speed and the new state.
// ----------------------------------------------------------------------------
// Usage:
//   Each request beat carries one sample of the four position switches and
//   the direction request. Each request beat yields exactly one response beat
//   with the drive speed command and the machine state after that tick.
//   The slow and fast speed magnitudes are written through the csr_ port
//   (index 0 slow, index 1 fast) while no beat is in flight.
// Pipeline and throughput:
//   A beat is captured in an input register, stepped through the machine
//   and lands in the response register. One beat is taken per cycle while
//   rsp_ready stays high, set by the single state update per cycle.
// Reset:
//   Synchronous reset puts the machine in init, clears the switch history
//   and the held speed, loads the default speeds and empties both registers.
// Stalls:
//   When the receiver holds rsp_ready low, the response register keeps its
//   beat and the input register can still take one more request; req_ready
//   drops only when both are full.
// ----------------------------------------------------------------------------
module door_drive_position_fsm (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ddp_pkg::req_type                      req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ddp_pkg::rsp_type                      rsp_payload,
   input  logic                                  csr_write_enable,
   input  logic [ddp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ddp_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   logic                          in_valid_ff;
   ddp_pkg::req_type              in_data_ff;
   logic                          out_valid_ff;
   ddp_pkg::rsp_type              out_data_ff;
   ddp_pkg::ctx_type              ctx_ff;
   ddp_pkg::ctx_type              ctx_in;
   logic [ddp_pkg::MAG_WIDTH-1:0] slow_speed_ff;
   logic [ddp_pkg::MAG_WIDTH-1:0] fast_speed_ff;
   logic                          step;

   // The input beat is stepped when the response register is free or draining.
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slow_speed_ff <= ddp_pkg::SLOW_SPEED_RESET;
         fast_speed_ff <= ddp_pkg::FAST_SPEED_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == ddp_pkg::CSR_SLOW_SPEED) slow_speed_ff <= csr_wdata;
         if (csr_index == ddp_pkg::CSR_FAST_SPEED) fast_speed_ff <= csr_wdata;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   // Machine step.
   ddp_next_state u_next_state (
      .cur        (ctx_ff),
      .req        (in_data_ff),
      .slow_speed (slow_speed_ff),
      .fast_speed (fast_speed_ff),
      .nxt        (ctx_in)
   );

   // Machine context, updated once per stepped beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.state         <= ddp_pkg::ST_INIT;
         ctx_ff.prev_switches <= '0;
         ctx_ff.speed         <= '0;
      end else if (step) begin
         ctx_ff <= ctx_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff.drive_speed <= ctx_in.speed;
         out_data_ff.door_state  <= ctx_in.state;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

### tb/door_drive_position_fsm_checker.sv
// ----------------------------------------------------------------------------
// Door drive position checker
// Watches the request, response and register ports of the door position
// machine, keeps its own copy of the machine and the speed registers, and
// compares every response beat field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module door_drive_position_fsm_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  ddp_pkg::req_type                    req_payload,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  ddp_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [ddp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ddp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                  failures,
   output int                                  pending
);

   // Predicted machine state and speed registers.
   ddp_pkg::door_state_type                door_pos;
   logic [ddp_pkg::SW_COUNT-1:0]           last_switches;
   logic signed [ddp_pkg::SPEED_WIDTH-1:0] held_speed;
   logic [ddp_pkg::MAG_WIDTH-1:0]          slow_mag;
   logic [ddp_pkg::MAG_WIDTH-1:0]          fast_mag;

   // Speed commands and states still owed by the block, oldest first.
   ddp_pkg::rsp_type due_commands[$];
   int               fail_count = 0;

   // Two's complement speed of the given magnitude and sign.
   function automatic logic signed [ddp_pkg::SPEED_WIDTH-1:0] signed_mag(
      input logic [ddp_pkg::MAG_WIDTH-1:0] mag,
      input logic                          negative
   );
      logic signed [ddp_pkg::SPEED_WIDTH-1:0] plain;
      plain = $signed({1'b0, mag});
      return negative ? -plain : plain;
   endfunction

   // One tick of the door machine. The speed follows the state held at the
   // start of the tick; the transition is taken afterwards.
   function automatic ddp_pkg::rsp_type step_door_machine(input ddp_pkg::req_type beat);
      logic [ddp_pkg::SW_COUNT-1:0] sw;
      logic [ddp_pkg::SW_COUNT-1:0] moved;
      logic                         d0;
      logic                         d1;
      ddp_pkg::door_state_type      nxt;
      ddp_pkg::rsp_type             outcome;
      sw    = {beat.switch_four, beat.switch_three, beat.switch_two, beat.switch_one};
      moved = sw ^ last_switches;
      d1    = beat.direction;
      d0    = !beat.direction;
      nxt   = door_pos;
      case (door_pos)
         ddp_pkg::ST_INIT: begin
            if (sw == '0) nxt = ddp_pkg::ST_UNSURE;
         end
         // All eight rules are tried in turn and the last match sticks.
         ddp_pkg::ST_UNSURE: begin
            if (d0 && moved[0]) nxt = ddp_pkg::ST_CLOSED;
            if (d1 && moved[0]) nxt = ddp_pkg::ST_NEG;
            if (d1 && moved[1]) nxt = ddp_pkg::ST_ACCNEG;
            if (d1 && moved[2]) nxt = ddp_pkg::ST_DECNEG;
            if (d1 && moved[3]) nxt = ddp_pkg::ST_OPEN;
            if (d0 && moved[3]) nxt = ddp_pkg::ST_POS;
            if (d0 && moved[2]) nxt = ddp_pkg::ST_ACCPOS;
            if (d0 && moved[1]) nxt = ddp_pkg::ST_DECPOS;
         end
         ddp_pkg::ST_CLOSED: begin
            held_speed = '0;
            if (d1) nxt = ddp_pkg::ST_NEG;
         end
         ddp_pkg::ST_NEG: begin
            held_speed = signed_mag(slow_mag, 1'b1);
            if (d1 && moved[1]) nxt = ddp_pkg::ST_ACCNEG;
            if (d0) nxt = ddp_pkg::ST_DECPOS;
         end
         ddp_pkg::ST_ACCNEG: begin
            held_speed = signed_mag(fast_mag, 1'b1);
            if (d1 && moved[2]) nxt = ddp_pkg::ST_DECNEG;
            if (d0) nxt = ddp_pkg::ST_ACCPOS;
         end
         ddp_pkg::ST_DECNEG: begin
            held_speed = signed_mag(slow_mag, 1'b1);
            if (d1 && moved[3]) nxt = ddp_pkg::ST_OPEN;
            if (d0) nxt = ddp_pkg::ST_POS;
         end
         ddp_pkg::ST_OPEN: begin
            held_speed = '0;
            if (d0) nxt = ddp_pkg::ST_POS;
         end
         ddp_pkg::ST_POS: begin
            held_speed = signed_mag(slow_mag, 1'b0);
            if (d0 && moved[2]) nxt = ddp_pkg::ST_ACCPOS;
            if (d1) nxt = ddp_pkg::ST_DECNEG;
         end
         ddp_pkg::ST_ACCPOS: begin
            held_speed = signed_mag(fast_mag, 1'b0);
            if (d0 && moved[1]) nxt = ddp_pkg::ST_DECPOS;
            if (d1) nxt = ddp_pkg::ST_ACCNEG;
         end
         ddp_pkg::ST_DECPOS: begin
            held_speed = signed_mag(slow_mag, 1'b0);
            if (d0 && moved[0]) nxt = ddp_pkg::ST_CLOSED;
            if (d1) nxt = ddp_pkg::ST_NEG;
         end
         default: begin
         end
      endcase
      door_pos      = nxt;
      last_switches = sw;
      outcome.drive_speed = held_speed;
      outcome.door_state  = nxt;
      return outcome;
   endfunction

   // Follow register writes and both channels; compare each response beat.
   always @(posedge clock) begin
      ddp_pkg::rsp_type want;
      if (reset) begin
         door_pos      = ddp_pkg::ST_INIT;
         last_switches = '0;
         held_speed    = '0;
         slow_mag      = ddp_pkg::SLOW_SPEED_RESET;
         fast_mag      = ddp_pkg::FAST_SPEED_RESET;
         due_commands.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               ddp_pkg::CSR_SLOW_SPEED: slow_mag = csr_wdata;
               ddp_pkg::CSR_FAST_SPEED: fast_mag = csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (due_commands.size() == 0) begin
               $error("response beat with no request waiting: drive_speed %0d, door_state %0d",
                      rsp_payload.drive_speed, rsp_payload.door_state);
               fail_count++;
            end else begin
               want = due_commands.pop_front();
               if (rsp_payload.drive_speed !== want.drive_speed) begin
                  $error("drive_speed mismatch: expected %0d, actual %0d",
                         want.drive_speed, rsp_payload.drive_speed);
                  fail_count++;
               end
               if (rsp_payload.door_state !== want.door_state) begin
                  $error("door_state mismatch: expected %0d, actual %0d",
                         want.door_state, rsp_payload.door_state);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) due_commands.push_back(step_door_machine(req_payload));
      end
      failures <= fail_count;
      pending  <= due_commands.size();
   end

endmodule

### tb/door_drive_position_fsm_tb.sv
// ----------------------------------------------------------------------------
// Door drive position machine testbench
// Drives switch samples through the door position machine: a directed walk
// through every state and most transitions, then random door travels with
// noise under several speed settings, with random idle bursts on both sides.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module door_drive_position_fsm_tb;

   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_BEATS  = 200;
   localparam int PHASE_COUNT  = 6;

   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                req_valid        = 1'b0;
   logic                                req_ready;
   ddp_pkg::req_type                    req_payload      = '0;
   logic                                rsp_valid;
   logic                                rsp_ready        = 1'b0;
   ddp_pkg::rsp_type                    rsp_payload;
   logic                                csr_write_enable = 1'b0;
   logic [ddp_pkg::CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [ddp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata        = '0;
   int                                  failures;
   int                                  pending;

   logic                                idling_on        = 1'b1;
   int                                  stall_left       = 0;
   int                                  quiet_cycles     = 0;

   // Door model for the random part: switch levels and travel direction.
   logic [ddp_pkg::SW_COUNT-1:0]        door_switches    = '0;
   logic                                travel_dir       = 1'b0;

   door_drive_position_fsm uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   door_drive_position_fsm_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .pending          (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver side: random stall bursts on rsp_ready.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   // Watchdog: ends the run when no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one switch sample, after an optional idle burst. Switch bit 0 is
   // switch one, bit 3 switch four.
   task automatic send_beat(input logic [ddp_pkg::SW_COUNT-1:0] sw, input logic dir);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid                <= 1'b1;
      req_payload.switch_one   <= sw[0];
      req_payload.switch_two   <= sw[1];
      req_payload.switch_three <= sw[2];
      req_payload.switch_four  <= sw[3];
      req_payload.direction    <= dir;
      do @(posedge clock); while (!req_ready);
   endtask

   // Let every owed response arrive before returning.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write both speed magnitudes one after the other while idle.
   task automatic write_speeds(
      input logic [ddp_pkg::MAG_WIDTH-1:0] slow,
      input logic [ddp_pkg::MAG_WIDTH-1:0] fast
   );
      csr_write_enable <= 1'b1;
      csr_index        <= ddp_pkg::CSR_SLOW_SPEED;
      csr_wdata        <= slow;
      @(posedge clock);
      csr_index        <= ddp_pkg::CSR_FAST_SPEED;
      csr_wdata        <= fast;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [ddp_pkg::MAG_WIDTH-1:0] slow_set;
      logic [ddp_pkg::MAG_WIDTH-1:0] fast_set;
      logic [1:0]                    flip_bit;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed walk with the reset speeds. Init holds while any switch is
      // set and leaves once all read zero.
      send_beat(4'b1111, 1'b0);
      send_beat(4'b0101, 1'b1);
      send_beat(4'b0000, 1'b0);
      // Unknown holds with no zone change; then switches one and two change
      // together, and the later rule (decpos) must win over closed.
      send_beat(4'b0000, 1'b1);
      send_beat(4'b0011, 1'b0);
      // Full closing and opening travel through every zone.
      send_beat(4'b0010, 1'b0);
      send_beat(4'b0010, 1'b1);
      send_beat(4'b0000, 1'b1);
      send_beat(4'b0100, 1'b1);
      send_beat(4'b1100, 1'b1);
      send_beat(4'b1100, 1'b0);
      send_beat(4'b1000, 1'b0);
      send_beat(4'b1010, 1'b0);
      // Direction reversals out of every moving state.
      send_beat(4'b1010, 1'b1);
      send_beat(4'b1010, 1'b0);
      send_beat(4'b1010, 1'b1);
      send_beat(4'b1000, 1'b1);
      send_beat(4'b1000, 1'b0);
      send_beat(4'b1000, 1'b1);
      send_beat(4'b1100, 1'b1);
      send_beat(4'b1100, 1'b0);
      send_beat(4'b1100, 1'b1);
      door_switches = 4'b1100;
      travel_dir    = 1'b1;

      // Random phases, each under its own speed setting; the last runs
      // without idling.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         case (phase)
            0:       begin slow_set = 10'd1023; fast_set = 10'd0;    end
            1:       begin slow_set = 10'd0;    fast_set = 10'd1023; end
            2:       begin slow_set = 10'd1023; fast_set = 10'd1023; end
            3:       begin slow_set = 10'd0;    fast_set = 10'd0;    end
            default: begin
               slow_set = 10'($urandom_range(0, 1023));
               fast_set = 10'($urandom_range(0, 1023));
            end
         endcase
         write_speeds(slow_set, fast_set);
         if (phase == PHASE_COUNT - 1) idling_on <= 1'b0;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // Mostly door travel: occasional reversals and single switch
            // edges; the rest is random noise on all inputs.
            if ($urandom_range(0, 9) < 8) begin
               if ($urandom_range(0, 7) == 0) travel_dir = !travel_dir;
               if ($urandom_range(0, 1) == 0) begin
                  flip_bit = 2'($urandom_range(0, ddp_pkg::SW_COUNT - 1));
                  door_switches[flip_bit] ^= 1'b1;
               end
            end else begin
               door_switches = 4'($urandom_range(0, 15));
               travel_dir    = 1'($urandom_range(0, 1));
            end
            send_beat(door_switches, travel_dir);
         end
      end

      drain();
      if (failures == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
